[rtl/core/zfe_pkg.sv]
package zfe_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_W = 13;
  localparam int QUOT_W = 17;
  localparam int DIV_STEPS = QUOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int DEF_MAX_SYMBOL_SAMPLES = 8192;
  localparam int SPS_RESET = 736;

  localparam logic [31:0] POWER_FLOOR = 32'd1000;
  localparam logic [QUOT_W-1:0] SAT_POS_MAG = 17'd32767;
  localparam logic [QUOT_W-1:0] SAT_NEG_MAG = 17'd32768;
  localparam logic signed [DATA_W-1:0] SAT_HIGH = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_LOW = 16'sh8000;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic est_load;
    logic mul;
    logic pwr;
    logic prep;
    logic div_step;
    logic out_load;
  } zfe_cmd_t;

  typedef struct packed {
    logic div_last;
  } zfe_sts_t;

endpackage

[rtl/core/zfe_if.sv]
interface zfe_in_if;
  logic valid;
  logic ready;
  zfe_pkg::sample_t sample_re;
  zfe_pkg::sample_t sample_im;
  logic last_in;

  modport source (output valid, output sample_re, output sample_im, output last_in,
                  input ready);
  modport sink (input valid, input sample_re, input sample_im, input last_in,
                output ready);
endinterface

interface zfe_out_if;
  logic valid;
  logic ready;
  zfe_pkg::sample_t eq_re;
  zfe_pkg::sample_t eq_im;
  logic last_out;

  modport source (output valid, output eq_re, output eq_im, output last_out,
                  input ready);
  modport sink (input valid, input eq_re, input eq_im, input last_out,
                output ready);
endinterface

[rtl/core/zfe_ctrl.sv]
module zfe_ctrl #(
  parameter int MAX_SYMBOL_SAMPLES = zfe_pkg::DEF_MAX_SYMBOL_SAMPLES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        cfg_we,
  input  logic [zfe_pkg::CFG_W-1:0]   cfg_wdata,
  output zfe_pkg::zfe_cmd_t           cmd,
  input  zfe_pkg::zfe_sts_t           sts
);
  import zfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOL_SAMPLES);
  localparam logic [CNT_W-1:0] SPS_MAX = CNT_W'(MAX_SYMBOL_SAMPLES - 1);
  localparam logic [CNT_W-1:0] SPS_RST =
      (SPS_RESET >= MAX_SYMBOL_SAMPLES) ? SPS_MAX : CNT_W'(SPS_RESET);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PWR,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             in_ready_r, in_ready_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             est_r, est_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] sps_r, sps_nxt;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && in_ready_r;
  assign out_free = !out_valid_r || out_ready;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.est_load = accept && (left_r == '0);
    cmd.mul      = (state_r == ST_MUL);
    cmd.pwr      = (state_r == ST_PWR);
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    est_nxt       = est_r;
    left_nxt      = left_r;
    sps_nxt       = sps_r;

    if (cfg_we) begin
      sps_nxt = (32'(cfg_wdata) >= 32'(MAX_SYMBOL_SAMPLES)) ? SPS_MAX : CNT_W'(cfg_wdata);
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          in_ready_nxt = 1'b0;
          state_nxt    = ST_MUL;
          if (left_r == '0) begin
            est_nxt  = 1'b1;
            left_nxt = sps_r;
          end else begin
            est_nxt  = 1'b0;
            left_nxt = left_r - 1'b1;
          end
        end
      end
      ST_MUL: begin
        state_nxt = est_r ? ST_PWR : ST_PREP;
      end
      ST_PWR: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
      ST_PREP: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      est_r       <= 1'b0;
      left_r      <= '0;
      sps_r       <= SPS_RST;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      left_r      <= left_nxt;
      sps_r       <= sps_nxt;
    end
  end

endmodule

[rtl/core/zfe_datapath.sv]
module zfe_datapath (
  input  logic                 clk,
  input  zfe_pkg::zfe_cmd_t    cmd,
  output zfe_pkg::zfe_sts_t    sts,
  input  zfe_pkg::sample_t     in_sample_re,
  input  zfe_pkg::sample_t     in_sample_im,
  input  logic                 in_last,
  output zfe_pkg::sample_t     eq_re,
  output zfe_pkg::sample_t     eq_im,
  output logic                 last_out
);
  import zfe_pkg::*;

  sample_t                smp_re_r, smp_im_r;
  sample_t                chan_re_r, chan_im_r;
  logic                   last_r;
  logic [31:0]            pwr_r;
  logic signed [31:0]     prod0_r, prod1_r, prod2_r, prod3_r;

  logic [31:0]            rem_re_r, rem_im_r;
  logic [QUOT_W-1:0]      q_re_r, q_im_r;
  logic [QUOT_W-1:0]      dvd_re_r, dvd_im_r;
  logic                   neg_re_r, neg_im_r;
  logic                   ovf_re_r, ovf_im_r;
  logic [DIV_CNT_W-1:0]   cnt_r;

  sample_t                eq_re_r, eq_im_r;
  logic                   last_out_r;

  logic [32:0]            pwr_sum;
  logic signed [31:0]     w_re, w_im;
  logic [31:0]            mag_re, mag_im;
  logic [32:0]            t_re, t_im;
  logic                   ge_re, ge_im;

  function automatic sample_t sat_quot(input logic [QUOT_W-1:0] q, input logic ovf,
                                       input logic neg);
    logic [QUOT_W-1:0] nq;
    nq = ~q + 1'b1;
    if (!neg) begin
      return (ovf || q > SAT_POS_MAG) ? SAT_HIGH : sample_t'(q[DATA_W-1:0]);
    end
    return (ovf || q > SAT_NEG_MAG) ? SAT_LOW : sample_t'(nq[DATA_W-1:0]);
  endfunction

  assign pwr_sum = 33'(unsigned'(prod0_r)) + 33'(unsigned'(prod1_r));

  // numerators, wrapped to 32 bits
  assign w_re   = prod0_r + prod1_r;
  assign w_im   = prod2_r - prod3_r;
  assign mag_re = w_re[31] ? 32'(-w_re) : unsigned'(w_re);
  assign mag_im = w_im[31] ? 32'(-w_im) : unsigned'(w_im);

  // one restoring step per cycle, both parts side by side
  assign t_re  = {rem_re_r, dvd_re_r[QUOT_W-1]};
  assign t_im  = {rem_im_r, dvd_im_r[QUOT_W-1]};
  assign ge_re = t_re >= {1'b0, pwr_r};
  assign ge_im = t_im >= {1'b0, pwr_r};

  assign sts.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_re_r <= in_sample_re;
      smp_im_r <= in_sample_im;
      last_r   <= in_last;
    end
    if (cmd.est_load) begin
      chan_re_r <= in_sample_re;
      chan_im_r <= in_sample_im;
    end
    // for an estimate the stored channel is the sample itself, so these give |H|^2 terms
    if (cmd.mul) begin
      prod0_r <= smp_re_r * chan_re_r;
      prod1_r <= smp_im_r * chan_im_r;
      prod2_r <= smp_im_r * chan_re_r;
      prod3_r <= smp_re_r * chan_im_r;
    end
    if (cmd.pwr) begin
      pwr_r <= (pwr_sum < 33'(POWER_FLOOR)) ? POWER_FLOOR : pwr_sum[31:0];
    end
    if (cmd.prep) begin
      neg_re_r <= w_re[31];
      neg_im_r <= w_im[31];
      rem_re_r <= {2'b00, mag_re[31:2]};
      rem_im_r <= {2'b00, mag_im[31:2]};
      // quotient of 2^17 or more saturates either way
      ovf_re_r <= {2'b00, mag_re[31:2]} >= pwr_r;
      ovf_im_r <= {2'b00, mag_im[31:2]} >= pwr_r;
      dvd_re_r <= {mag_re[1:0], 15'd0};
      dvd_im_r <= {mag_im[1:0], 15'd0};
      q_re_r   <= '0;
      q_im_r   <= '0;
      cnt_r    <= DIV_CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_re_r <= ge_re ? 32'(t_re - {1'b0, pwr_r}) : t_re[31:0];
      rem_im_r <= ge_im ? 32'(t_im - {1'b0, pwr_r}) : t_im[31:0];
      q_re_r   <= {q_re_r[QUOT_W-2:0], ge_re};
      q_im_r   <= {q_im_r[QUOT_W-2:0], ge_im};
      dvd_re_r <= {dvd_re_r[QUOT_W-2:0], 1'b0};
      dvd_im_r <= {dvd_im_r[QUOT_W-2:0], 1'b0};
      cnt_r    <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      eq_re_r    <= sat_quot(q_re_r, ovf_re_r, neg_re_r);
      eq_im_r    <= sat_quot(q_im_r, ovf_im_r, neg_im_r);
      last_out_r <= last_r;
    end
  end

  assign eq_re    = eq_re_r;
  assign eq_im    = eq_im_r;
  assign last_out = last_out_r;

endmodule

[rtl/core/zero_forcing_equalizer.sv]
// single-tap zero-forcing equalizer, one channel estimate per symbol
// data sample path: multiply, prepare, restoring division of both parts side by side
//   against the shared power, output load; an estimate goes through multiply and power
// one item in flight: a new sample or estimate is accepted only once the last is through,
//   and a held result delays the next accept
// reset: synchronous active-low, next item is an estimate, samples per symbol 736
module zero_forcing_equalizer #(
  parameter int MAX_SYMBOL_SAMPLES = zfe_pkg::DEF_MAX_SYMBOL_SAMPLES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  zfe_in_if.sink                    in_ch,
  zfe_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [zfe_pkg::CFG_W-1:0] cfg_wdata
);
  import zfe_pkg::*;

  zfe_cmd_t cmd;
  zfe_sts_t sts;

  zfe_ctrl #(
    .MAX_SYMBOL_SAMPLES(MAX_SYMBOL_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  zfe_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample_re (in_ch.sample_re),
    .in_sample_im (in_ch.sample_im),
    .in_last      (in_ch.last_in),
    .eq_re        (out_ch.eq_re),
    .eq_im        (out_ch.eq_im),
    .last_out     (out_ch.last_out)
  );

endmodule

[rtl/core/zfe_checker.sv]
module zfe_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input zfe_pkg::sample_t eq_re,
  input zfe_pkg::sample_t eq_im,
  input logic             last_out
);
  import zfe_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(eq_re) && $stable(eq_im)
      && $stable(last_out))
    else $error("result beat changed while stalled");

  // one item in flight: an accepted beat drops ready
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a new result only comes out of the busy phase
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear handshake state");

endmodule

bind zero_forcing_equalizer zfe_checker u_zfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .eq_re     (out_ch.eq_re),
  .eq_im     (out_ch.eq_im),
  .last_out  (out_ch.last_out)
);

[test/tb_zero_forcing_equalizer.sv]
`timescale 1ns / 100ps

module tb_zero_forcing_equalizer;
  import zfe_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    sample_t eq_re;
    sample_t eq_im;
    logic    last_out;
  } eq_result_t;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  class eq_checker;
    logic [CFG_W-1:0] sym_len;
    logic [CFG_W-1:0] samples_left;
    sample_t          h_re;
    sample_t          h_im;
    logic [31:0]      h_pow;
    eq_result_t       expected_eq[$];
    int errors;
    int results_seen;
    int estimates;
    int floored;
    int saturated;
    int wrapped;

    function new();
      sym_len = CFG_W'(SPS_RESET);
      samples_left = '0;
      h_re = '0;
      h_im = '0;
      h_pow = POWER_FLOOR;
      errors = 0;
      results_seen = 0;
      estimates = 0;
      floored = 0;
      saturated = 0;
      wrapped = 0;
    endfunction

    function void set_len(logic [CFG_W-1:0] v);
      sym_len = v;
    endfunction

    function sample_t clip(longint v);
      if (v > SAT_HIGH) begin
        saturated++;
        return SAT_HIGH;
      end
      if (v < SAT_LOW) begin
        saturated++;
        return SAT_LOW;
      end
      return v[DATA_W-1:0];
    endfunction

    // one accepted input beat: either a new channel estimate or a data sample
    function void note_sample(sample_t re, sample_t im, logic lst);
      longint acc_re;
      longint acc_im;
      longint divisor;
      int wr_re;
      int wr_im;
      eq_result_t r;
      if (samples_left == 0) begin
        acc_re = longint'(re) * re + longint'(im) * im;
        if (acc_re < longint'(POWER_FLOOR)) begin
          acc_re = longint'(POWER_FLOOR);
          floored++;
        end
        h_re = re;
        h_im = im;
        h_pow = acc_re[31:0];
        samples_left = sym_len;
        estimates++;
        return;
      end
      acc_re = longint'(re) * h_re + longint'(im) * h_im;
      acc_im = longint'(im) * h_re - longint'(re) * h_im;
      // product sums wrap to 32 bits before the shift
      wr_re = int'(acc_re);
      wr_im = int'(acc_im);
      if (longint'(wr_re) != acc_re || longint'(wr_im) != acc_im) wrapped++;
      divisor = h_pow;
      r.eq_re = clip((longint'(wr_re) * 32768) / divisor);
      r.eq_im = clip((longint'(wr_im) * 32768) / divisor);
      r.last_out = lst;
      expected_eq.push_back(r);
      samples_left--;
    endfunction

    function void check_result(sample_t re, sample_t im, logic lst);
      eq_result_t want;
      results_seen++;
      if (expected_eq.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: re=%0d im=%0d last=%0b", re, im, lst);
        errors++;
        return;
      end
      want = expected_eq.pop_front();
      if (want.eq_re !== re || want.eq_im !== im || want.last_out !== lst) begin
        if (errors < 10)
          $display("result %0d: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                   results_seen, want.eq_re, want.eq_im, want.last_out, re, im, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit hold_req;
  int len_writes;

  zfe_in_if in_if();
  zfe_out_if out_if();

  eq_checker sb = new();

  zero_forcing_equalizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sample_t corner_value();
    case ($urandom_range(0, 5))
      0: return SAT_LOW;
      1: return SAT_HIGH;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      default: return SAT_LOW + 16'sd1;
    endcase
  endfunction

  task automatic send(sample_t re, sample_t im, logic lst);
    in_if.valid <= 1'b1;
    in_if.sample_re <= re;
    in_if.sample_im <= im;
    in_if.last_in <= lst;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(re, im, lst);
  endtask

  // waits until every result is out and lets the pipeline settle, then writes the length
  task automatic write_sym_len(logic [CFG_W-1:0] v);
    while (sb.expected_eq.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_len(v);
    len_writes++;
  endtask

  task automatic run_phase(int n_items, bit with_hold);
    int sent;
    int burst;
    int gap;
    sample_t re;
    sample_t im;
    logic lst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        if (with_hold && sent == n_items / 3) hold_req = 1'b1;
        if (sb.samples_left == 0) begin
          // estimate: tiny ones hit the power floor, small ones saturate
          case ($urandom_range(0, 5))
            0: begin
              re = 16'($signed($urandom_range(0, 62)) - 31);
              im = 16'($signed($urandom_range(0, 62)) - 31);
            end
            1: begin
              re = 16'($signed($urandom_range(0, 4000)) - 2000);
              im = 16'($signed($urandom_range(0, 4000)) - 2000);
            end
            2: begin
              re = 16'($signed($urandom_range(0, 512)) - 256);
              im = 16'($signed($urandom_range(0, 512)) - 256);
            end
            3: begin
              re = corner_value();
              im = corner_value();
            end
            default: begin
              re = 16'($urandom());
              im = 16'($urandom());
            end
          endcase
        end else begin
          case ($urandom_range(0, 5))
            4: begin
              re = corner_value();
              im = corner_value();
            end
            5: begin
              re = 16'($signed($urandom_range(0, 200)) - 100);
              im = 16'($signed($urandom_range(0, 200)) - 100);
            end
            default: begin
              re = 16'($urandom());
              im = 16'($urandom());
            end
          endcase
        end
        lst = 1'($urandom_range(0, 1));
        send(re, im, lst);
        sent++;
      end
      if (sent < n_items) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // result side: check accepted beats, then pick ready for the next cycle
  initial begin
    rx_mode_t mode;
    int cnt;
    mode = RX_ALWAYS;
    cnt = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.eq_re, out_if.eq_im, out_if.last_out);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_if.ready <= ((cnt % 9) < 4);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
        cnt++;
        if (cnt % 173 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    len_writes = 0;
    in_if.valid = 1'b0;
    in_if.sample_re = '0;
    in_if.sample_im = '0;
    in_if.last_in = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_sym_len(13'd3);
    // zero estimate falls back to the power floor, its marker is ignored
    send(16'sd0, 16'sd0, 1'b1);
    send(SAT_HIGH, SAT_HIGH, 1'b1);
    send(SAT_LOW, SAT_LOW, 1'b0);
    send(16'sd1, 16'sd1, 1'b1);
    // largest power, and a product sum that wraps past 32 bits
    send(SAT_LOW, SAT_LOW, 1'b0);
    send(SAT_LOW, SAT_LOW, 1'b1);
    send(SAT_HIGH, SAT_LOW, 1'b0);
    send(SAT_LOW, SAT_HIGH, 1'b1);
    // unit estimate: quotients saturate both ways
    send(16'sd1, 16'sd0, 1'b0);
    send(SAT_HIGH, SAT_LOW, 1'b0);
    send(-16'sd1, 16'sd1, 1'b1);
    send(16'sd0, 16'sd0, 1'b0);
    send(SAT_HIGH, SAT_LOW, 1'b1);
    send(SAT_HIGH, SAT_HIGH, 1'b0);
    send(SAT_LOW, 16'sd0, 1'b1);
    send(16'sd123, -16'sd4567, 1'b0);
    in_if.valid <= 1'b0;

    // zero length: every beat is a fresh estimate
    write_sym_len(13'd0);
    send(16'sd100, 16'sd200, 1'b1);
    send(-16'sd5, 16'sd7, 1'b0);
    send(SAT_HIGH, SAT_HIGH, 1'b1);
    in_if.valid <= 1'b0;

    write_sym_len(13'd1);
    send(16'sd20000, -16'sd15000, 1'b1);
    send(SAT_LOW, SAT_HIGH, 1'b1);
    send(-16'sd700, 16'sd300, 1'b0);
    send(SAT_HIGH, 16'sd0, 1'b0);
    in_if.valid <= 1'b0;

    write_sym_len(13'd1);
    run_phase(85, 1'b0);
    write_sym_len(13'd2);
    run_phase(80, 1'b1);
    write_sym_len(13'd7);
    run_phase(77, 1'b0);
    write_sym_len(13'($urandom_range(1, 40)));
    run_phase(83, 1'b0);
    write_sym_len(13'd4);
    run_phase(71, 1'b0);
    write_sym_len(13'd13);
    run_phase(79, 1'b0);
    write_sym_len(13'($urandom_range(1, 12)));
    run_phase(81, 1'b0);
    write_sym_len(13'd8191);
    run_phase(110, 1'b1);

    while (sb.expected_eq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d estimates (%0d at the power floor) and %0d results over %0d length settings",
             sb.estimates, sb.floored, sb.results_seen, len_writes);
    $display("%0d saturated parts, %0d wrapped product sums, %0d errors",
             sb.saturated, sb.wrapped, sb.errors);
    if (sb.errors == 0 && sb.expected_eq.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
